/* hdl/assert_macros.svh */
// Assertion macros shared by the LED bar driver RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(name, clk, rst, expr)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`endif
`endif

/* hdl/bbsd_pkg.sv */
// Package for the LED bar serial driver: widths, opcodes, microcode
// format and program, command bytes and the segment table. No dependencies.
package bbsd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int PROD_WIDTH  = COUNT_WIDTH + 4;
  localparam int PCT_STEPS   = 10;
  localparam int IDX_WIDTH   = 4;

  localparam logic [7:0] CMD_DATA    = 8'h44;
  localparam logic [7:0] ADDR_HIGH   = 8'hC0;
  localparam logic [7:0] ADDR_LOW    = 8'hC1;
  localparam logic [7:0] CMD_DISPLAY = 8'h8A;

  localparam logic [2:0] POS_CMD0      = 3'd0;
  localparam logic [2:0] POS_ADDR_HIGH = 3'd1;
  localparam logic [2:0] POS_DATA_HIGH = 3'd2;
  localparam logic [2:0] POS_CMD1      = 3'd3;
  localparam logic [2:0] POS_ADDR_LOW  = 3'd4;
  localparam logic [2:0] POS_DATA_LOW  = 3'd5;
  localparam logic [2:0] LAST_LEVEL    = 3'd3;
  localparam logic [2:0] LAST_RAW      = 3'd6;
  localparam logic [2:0] BIT_LAST      = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEVEL = 2'd1,
    OP_RAW   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIV,
    CS_REPORT
  } ctl_state_t;

  typedef enum logic [3:0] {
    UA_ST0, UA_ST1, UA_ST2,
    UA_BT0, UA_BT1, UA_BT2,
    UA_AK0, UA_AK1, UA_AK2,
    UA_SP0, UA_SP1, UA_SP2, UA_SP3
  } upc_t;

  typedef enum logic [1:0] {
    PO_KEEP,
    PO_LOW,
    PO_HIGH,
    PO_DATA
  } pin_op_t;

  typedef enum logic [1:0] {
    CD_NONE,
    CD_BIT_LAST,
    CD_BYTE_ENDS,
    CD_BYTE_LAST
  } cond_t;

  typedef struct packed {
    pin_op_t clk_op;
    pin_op_t dio_op;
    pin_op_t rel_op;
    logic    bit_clr;
    cond_t   cond;
    logic    bit_inc_f;
    logic    byte_inc_f;
    logic    halt_t;
    upc_t    next_t;
    upc_t    next_f;
  } uword_t;

  typedef struct packed {
    logic       tick;
    logic       start;
    logic       raw;
    logic [7:0] high_byte;
    logic [7:0] low_byte;
  } seq_cmd_t;

  typedef struct packed {
    logic clk;
    logic dio;
    logic rel;
    logic busy;
  } pin_state_t;

  function automatic uword_t ucode(input upc_t addr);
    uword_t uw;
    uw = '0;
    case (addr)
      UA_ST0: begin
        uw.clk_op = PO_HIGH; uw.dio_op = PO_HIGH; uw.next_f = UA_ST1;
      end
      UA_ST1: begin
        uw.dio_op = PO_LOW; uw.next_f = UA_ST2;
      end
      UA_ST2: begin
        uw.clk_op = PO_LOW; uw.bit_clr = 1'b1; uw.next_f = UA_BT0;
      end
      UA_BT0: begin
        uw.clk_op = PO_LOW; uw.next_f = UA_BT1;
      end
      UA_BT1: begin
        uw.dio_op = PO_DATA; uw.next_f = UA_BT2;
      end
      UA_BT2: begin
        uw.clk_op = PO_HIGH; uw.cond = CD_BIT_LAST; uw.bit_inc_f = 1'b1;
        uw.next_t = UA_AK0; uw.next_f = UA_BT0;
      end
      UA_AK0: begin
        uw.clk_op = PO_LOW; uw.rel_op = PO_HIGH; uw.next_f = UA_AK1;
      end
      UA_AK1: begin
        uw.clk_op = PO_HIGH; uw.next_f = UA_AK2;
      end
      UA_AK2: begin
        uw.clk_op = PO_LOW; uw.rel_op = PO_LOW; uw.dio_op = PO_LOW;
        uw.bit_clr = 1'b1; uw.cond = CD_BYTE_ENDS; uw.byte_inc_f = 1'b1;
        uw.next_t = UA_SP0; uw.next_f = UA_BT0;
      end
      UA_SP0: begin
        uw.clk_op = PO_LOW; uw.next_f = UA_SP1;
      end
      UA_SP1: begin
        uw.dio_op = PO_LOW; uw.next_f = UA_SP2;
      end
      UA_SP2: begin
        uw.clk_op = PO_HIGH; uw.next_f = UA_SP3;
      end
      UA_SP3: begin
        uw.dio_op = PO_HIGH; uw.cond = CD_BYTE_LAST; uw.byte_inc_f = 1'b1;
        uw.halt_t = 1'b1; uw.next_t = UA_ST0; uw.next_f = UA_ST0;
      end
      default: uw.next_f = UA_ST0;
    endcase
    return uw;
  endfunction

  function automatic logic [7:0] byte_at(input logic raw, input logic [2:0] idx,
                                         input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] b;
    case (idx)
      POS_CMD0:      b = CMD_DATA;
      POS_ADDR_HIGH: b = ADDR_HIGH;
      POS_DATA_HIGH: b = hi;
      POS_CMD1:      b = raw ? CMD_DATA : CMD_DISPLAY;
      POS_ADDR_LOW:  b = ADDR_LOW;
      POS_DATA_LOW:  b = lo;
      default:       b = CMD_DISPLAY;
    endcase
    return b;
  endfunction

  function automatic logic byte_ends(input logic raw, input logic [2:0] idx);
    return !(idx == POS_ADDR_HIGH || (raw && idx == POS_ADDR_LOW));
  endfunction

  function automatic logic [7:0] seg_byte(input logic [IDX_WIDTH-1:0] idx);
    logic [7:0] s;
    case (idx)
      4'd0:          s = 8'h00;
      4'd1, 4'd2:    s = 8'h40;
      4'd3:          s = 8'h60;
      4'd4:          s = 8'h70;
      4'd5:          s = 8'h78;
      4'd6, 4'd7:    s = 8'h7C;
      4'd8, 4'd9:    s = 8'h7E;
      default:       s = 8'h7F;
    endcase
    return s;
  endfunction

endpackage

/* hdl/bbsd_if.sv */
// Channel interfaces of the LED bar serial driver: request, result, config.
// Depends on bbsd_pkg.
interface bbsd_req_if import bbsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [COUNT_WIDTH-1:0] count;
  logic [7:0]             raw_high;
  logic [7:0]             raw_low;

  modport source (output valid, opcode, count, raw_high, raw_low, input ready);
  modport sink   (input valid, opcode, count, raw_high, raw_low, output ready);
endinterface

interface bbsd_res_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic dio_released;
  logic busy_res;
  logic accepted;

  modport source (output valid, clk_level, dio_level, dio_released, busy_res, accepted,
                  input ready);
  modport sink   (input valid, clk_level, dio_level, dio_released, busy_res, accepted,
                  output ready);
endinterface

interface bbsd_cfg_if import bbsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

/* hdl/battery_bar_serial_driver.sv */
// LED bar serial driver top: request handling, capacity register, result register.
// Ticks, raw writes and dropped requests: the result is loaded from the report state,
// which waits while the result register is still full. Accepted level request: the quotient
// unit runs its 10 steps first, then the report state loads the result.
// One request in flight; a new one is taken while a result still waits.
// Sync reset: sequencer idle, pins clk=1 dio=1 driven, capacity zero. Uses bbsd_pkg.
`include "assert_macros.svh"
module battery_bar_serial_driver import bbsd_pkg::*; (
  input logic      clk,
  input logic      rst,
  bbsd_req_if.sink req,
  bbsd_res_if.source res,
  bbsd_cfg_if.sink cfg
);

  ctl_state_t             state, state_next;
  logic [COUNT_WIDTH-1:0] capacity;
  logic                   acc_flag;

  logic       fire;
  logic       div_go;
  logic       raw_go;
  logic       div_done;
  logic [7:0] div_seg;
  logic       out_load;
  seq_cmd_t   cmd;
  pin_state_t pins;

  bbsd_level_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .count    (req.count),
    .capacity (capacity),
    .done     (div_done),
    .seg      (div_seg)
  );

  bbsd_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .pins (pins)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg.valid) begin
      capacity <= cfg.capacity;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (fire) begin
          state_next = div_go ? CS_DIV : CS_REPORT;
        end
      end
      CS_DIV: begin
        if (div_done) begin
          state_next = CS_REPORT;
        end
      end
      CS_REPORT: begin
        if (out_load) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == CS_IDLE);
    fire      = req.valid && req.ready;
    div_go    = 1'b0;
    raw_go    = 1'b0;
    cmd       = '0;
    case (req.opcode)
      OP_TICK:  cmd.tick = fire;
      OP_LEVEL: div_go   = fire && !pins.busy && (capacity != '0);
      OP_RAW:   raw_go   = fire && !pins.busy;
      default:  ;
    endcase
    if (raw_go) begin
      cmd.start     = 1'b1;
      cmd.raw       = 1'b1;
      cmd.high_byte = req.raw_high;
      cmd.low_byte  = req.raw_low;
    end else if (state == CS_DIV && div_done) begin
      cmd.start     = 1'b1;
      cmd.high_byte = div_seg;
    end
    out_load = (state == CS_REPORT) && (!res.valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      acc_flag  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        acc_flag <= div_go || raw_go;
      end
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.clk_level    <= pins.clk;
      res.dio_level    <= pins.dio && !pins.rel;
      res.dio_released <= pins.rel;
      res.busy_res     <= pins.busy;
      res.accepted     <= acc_flag;
    end
  end

  `ASSERT_IMPLIES(a_start_when_idle, clk, rst, cmd.start, !pins.busy)
  `ASSERT_IMPLIES(a_div_only_waiting, clk, rst, div_done, state == CS_DIV)
  `ASSERT_IMPLIES(a_tick_not_start, clk, rst, cmd.tick, !cmd.start)

endmodule

/* hdl/bbsd_level_div.sv */
// Level quotient unit: min(10*count/capacity, 10) by compare and accumulate,
// one multiple of capacity per cycle, then the segment table. Uses bbsd_pkg.
`include "assert_macros.svh"
module bbsd_level_div import bbsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [COUNT_WIDTH-1:0] capacity,
  output logic                   done,
  output logic [7:0]             seg
);

  localparam logic [IDX_WIDTH-1:0] STEP_LAST = IDX_WIDTH'(PCT_STEPS - 1);

  logic                   running;
  logic [IDX_WIDTH-1:0]   step;
  logic [IDX_WIDTH-1:0]   idx;
  logic [PROD_WIDTH-1:0]  target;
  logic [PROD_WIDTH-1:0]  acc;
  logic [COUNT_WIDTH-1:0] cap;
  logic [PROD_WIDTH-1:0]  count_ext;

  assign count_ext = PROD_WIDTH'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (step == STEP_LAST);
      if (start) begin
        running <= 1'b1;
      end else if (running && (step == STEP_LAST)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      target <= (count_ext << 3) + (count_ext << 1);
      acc    <= PROD_WIDTH'(capacity);
      cap    <= capacity;
      idx    <= '0;
      step   <= '0;
    end else if (running) begin
      if (acc <= target) begin
        idx <= idx + 1'b1;
      end
      acc  <= acc + PROD_WIDTH'(cap);
      step <= step + 1'b1;
    end
  end

  assign seg = seg_byte(idx);

  `ASSERT_IMPLIES(a_idx_range, clk, rst, done, idx <= IDX_WIDTH'(PCT_STEPS))
  `ASSERT_IMPLIES(a_no_restart, clk, rst, running, !start)
  `ASSERT_IMPLIES(a_done_after_run, clk, rst, done, !running)

endmodule

/* hdl/bbsd_sequencer.sv */
// Microcoded pin sequencer: one control word per delay phase from the
// program in bbsd_pkg, with bit and byte counters and conditional jumps.
`include "assert_macros.svh"
module bbsd_sequencer import bbsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  seq_cmd_t   cmd,
  output pin_state_t pins
);

  logic       busy, busy_next;
  upc_t       upc, upc_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic [2:0] byte_idx, byte_idx_next;
  logic       raw_mode, raw_mode_next;
  logic [7:0] level_byte, level_byte_next;
  logic [7:0] low_byte, low_byte_next;
  logic       pin_clk, pin_clk_next;
  logic       pin_dio, pin_dio_next;
  logic       pin_rel, pin_rel_next;

  uword_t     uw;
  logic       taken;
  logic [7:0] cur_byte;
  logic [2:0] last_byte;

  function automatic logic pin_apply(input pin_op_t op, input logic cur, input logic data);
    logic v;
    case (op)
      PO_LOW:  v = 1'b0;
      PO_HIGH: v = 1'b1;
      PO_DATA: v = data;
      default: v = cur;
    endcase
    return v;
  endfunction

  assign uw        = ucode(upc);
  assign cur_byte  = byte_at(raw_mode, byte_idx, level_byte, low_byte);
  assign last_byte = raw_mode ? LAST_RAW : LAST_LEVEL;

  always_comb begin
    case (uw.cond)
      CD_BIT_LAST:  taken = (bit_idx == BIT_LAST);
      CD_BYTE_ENDS: taken = byte_ends(raw_mode, byte_idx);
      CD_BYTE_LAST: taken = (byte_idx >= last_byte);
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_next       = busy;
    upc_next        = upc;
    bit_idx_next    = bit_idx;
    byte_idx_next   = byte_idx;
    raw_mode_next   = raw_mode;
    level_byte_next = level_byte;
    low_byte_next   = low_byte;
    pin_clk_next    = pin_clk;
    pin_dio_next    = pin_dio;
    pin_rel_next    = pin_rel;
    if (cmd.start) begin
      busy_next       = 1'b1;
      upc_next        = UA_ST0;
      bit_idx_next    = '0;
      byte_idx_next   = '0;
      raw_mode_next   = cmd.raw;
      level_byte_next = cmd.high_byte;
      low_byte_next   = cmd.low_byte;
    end else if (cmd.tick && busy) begin
      pin_clk_next = pin_apply(uw.clk_op, pin_clk, 1'b0);
      pin_dio_next = pin_apply(uw.dio_op, pin_dio, cur_byte[bit_idx]);
      pin_rel_next = pin_apply(uw.rel_op, pin_rel, 1'b0);
      if (uw.bit_clr) begin
        bit_idx_next = '0;
      end else if (!taken && uw.bit_inc_f) begin
        bit_idx_next = bit_idx + 1'b1;
      end
      if (!taken && uw.byte_inc_f) begin
        byte_idx_next = byte_idx + 1'b1;
      end
      if (taken && uw.halt_t) begin
        busy_next = 1'b0;
      end
      upc_next = taken ? uw.next_t : uw.next_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      upc      <= UA_ST0;
      bit_idx  <= '0;
      byte_idx <= '0;
      raw_mode <= 1'b0;
      pin_clk  <= 1'b1;
      pin_dio  <= 1'b1;
      pin_rel  <= 1'b0;
    end else begin
      busy     <= busy_next;
      upc      <= upc_next;
      bit_idx  <= bit_idx_next;
      byte_idx <= byte_idx_next;
      raw_mode <= raw_mode_next;
      pin_clk  <= pin_clk_next;
      pin_dio  <= pin_dio_next;
      pin_rel  <= pin_rel_next;
    end
  end

  always_ff @(posedge clk) begin
    level_byte <= level_byte_next;
    low_byte   <= low_byte_next;
  end

  assign pins = '{clk: pin_clk, dio: pin_dio, rel: pin_rel, busy: busy};

  `ASSERT_IMPLIES(a_rel_in_seq, clk, rst, pin_rel, busy)
  `ASSERT_IMPLIES(a_idle_pins_high, clk, rst, !busy, pin_clk && pin_dio && !pin_rel)
  `ASSERT_IMPLIES(a_byte_in_range, clk, rst, busy, byte_idx <= last_byte)

endmodule

/* test/battery_bar_serial_driver_test.sv */
`timescale 1ns / 100ps
// Testbench for battery_bar_serial_driver: queue-fed request driver, result monitor and a
// pin-sequence predictor checking every result. Depends on bbsd_pkg and the bbsd_*_if channels.
module battery_bar_serial_driver_test import bbsd_pkg::*; ();

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int LEVEL_TICKS = 129;
  localparam int RAW_TICKS   = 224;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {BS_IDLE, BS_START, BS_BYTE, BS_STOP} bar_seq_t;
  typedef enum logic [1:0] {DM_NONE, DM_SEND, DM_RECV, DM_BOTH} drive_mode_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [7:0]             hi;
    logic [7:0]             lo;
  } bar_req_t;

  typedef struct packed {
    logic clk;
    logic dio;
    logic rel;
    logic busy;
    logic acc;
  } pin_result_t;

  logic clk = 1'b0;
  logic rst;

  bbsd_req_if req_ch();
  bbsd_res_if res_ch();
  bbsd_cfg_if cfg_ch();

  battery_bar_serial_driver dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always #2 clk = ~clk;

  bar_req_t    pending_reqs[$];
  pin_result_t expect_q[$];
  bar_req_t    nxt_req;
  drive_mode_t drive_mode;
  logic        req_fired;
  int          items_pushed = 0;
  int          items_accepted = 0;
  int          phase_items;
  int          bad_results = 0;
  int          stall_cycles;
  logic [COUNT_WIDTH-1:0] cap_now;

  // predictor state
  logic [COUNT_WIDTH-1:0] cap_model;
  logic [1:0] ph;
  bar_seq_t   kind;
  logic [2:0] bit_n;
  logic [2:0] byte_n;
  logic [7:0] hi_byte;
  logic [7:0] lo_byte;
  logic       raw_seq;
  logic       p_clk;
  logic       p_dio;
  logic       p_rel;
  logic       ack_phase;

  function automatic logic [7:0] bar_pattern(input logic [3:0] tenth);
    case (tenth)
      4'd0:       return 8'h00;
      4'd1, 4'd2: return 8'h40;
      4'd3:       return 8'h60;
      4'd4:       return 8'h70;
      4'd5:       return 8'h78;
      4'd6, 4'd7: return 8'h7C;
      4'd8, 4'd9: return 8'h7E;
      default:    return 8'h7F;
    endcase
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] idx);
    case (idx)
      POS_CMD0:      return CMD_DATA;
      POS_ADDR_HIGH: return ADDR_HIGH;
      POS_DATA_HIGH: return hi_byte;
      POS_CMD1:      return raw_seq ? CMD_DATA : CMD_DISPLAY;
      POS_ADDR_LOW:  return raw_seq ? ADDR_LOW : CMD_DISPLAY;
      POS_DATA_LOW:  return raw_seq ? lo_byte : CMD_DISPLAY;
      default:       return CMD_DISPLAY;
    endcase
  endfunction

  function automatic logic closes_txn(input logic [2:0] idx);
    if (idx == POS_ADDR_HIGH) return 1'b0;
    if (raw_seq && idx == POS_ADDR_LOW) return 1'b0;
    return 1'b1;
  endfunction

  task automatic reset_predictor();
    cap_model = '0;
    ph = 2'd0;
    kind = BS_IDLE;
    bit_n = 3'd0;
    byte_n = 3'd0;
    hi_byte = 8'h00;
    lo_byte = 8'h00;
    raw_seq = 1'b0;
    p_clk = 1'b1;
    p_dio = 1'b1;
    p_rel = 1'b0;
    ack_phase = 1'b0;
  endtask

  task automatic start_frame();
    kind = BS_START;
    ph = 2'd0;
    bit_n = 3'd0;
    byte_n = 3'd0;
    ack_phase = 1'b0;
  endtask

  task automatic advance_phase();
    logic [1:0] p;
    logic [7:0] b;
    p = ph;
    if (kind == BS_IDLE) return;
    case (kind)
      BS_START: begin
        if (p == 2'd0) begin
          p_clk = 1'b1;
          p_dio = 1'b1;
        end else if (p == 2'd1) begin
          p_dio = 1'b0;
        end else begin
          p_clk = 1'b0;
          kind = BS_BYTE;
          bit_n = 3'd0;
          ack_phase = 1'b0;
          p = 2'd3;
        end
      end
      BS_BYTE: begin
        if (!ack_phase) begin
          if (p == 2'd0) begin
            p_clk = 1'b0;
          end else if (p == 2'd1) begin
            b = frame_byte(byte_n);
            p_dio = b[bit_n];
          end else begin
            p_clk = 1'b1;
            if (bit_n == BIT_LAST) ack_phase = 1'b1;
            else bit_n = bit_n + 3'd1;
            p = 2'd3;
          end
        end else begin
          if (p == 2'd0) begin
            p_clk = 1'b0;
            p_rel = 1'b1;
          end else if (p == 2'd1) begin
            p_clk = 1'b1;
          end else begin
            p_clk = 1'b0;
            p_rel = 1'b0;
            p_dio = 1'b0;
            ack_phase = 1'b0;
            bit_n = 3'd0;
            if (closes_txn(byte_n)) kind = BS_STOP;
            else byte_n = byte_n + 3'd1;
            p = 2'd3;
          end
        end
      end
      default: begin
        if (p == 2'd0) begin
          p_clk = 1'b0;
        end else if (p == 2'd1) begin
          p_dio = 1'b0;
        end else if (p == 2'd2) begin
          p_clk = 1'b1;
        end else begin
          p_dio = 1'b1;
          if (byte_n >= (raw_seq ? LAST_RAW : LAST_LEVEL)) begin
            kind = BS_IDLE;
          end else begin
            byte_n = byte_n + 3'd1;
            kind = BS_START;
          end
        end
      end
    endcase
    ph = (p == 2'd3) ? 2'd0 : p + 2'd1;
  endtask

  task automatic bar_predict(input bar_req_t r);
    pin_result_t e;
    logic [63:0] prod;
    logic [63:0] pct;
    logic        idle_now;
    e = '0;
    idle_now = (kind == BS_IDLE);
    case (r.op)
      OP_TICK: advance_phase();
      OP_LEVEL: begin
        if (idle_now && cap_model != '0) begin
          prod = 64'(r.cnt) * 64'd100;
          pct = prod / 64'(cap_model);
          if (pct > 64'd100) pct = 64'd100;
          hi_byte = bar_pattern(4'(pct / 64'd10));
          raw_seq = 1'b0;
          start_frame();
          e.acc = 1'b1;
        end
      end
      OP_RAW: begin
        if (idle_now) begin
          hi_byte = r.hi;
          lo_byte = r.lo;
          raw_seq = 1'b1;
          start_frame();
          e.acc = 1'b1;
        end
      end
      default: ;
    endcase
    e.clk = p_clk;
    e.dio = p_rel ? 1'b0 : p_dio;
    e.rel = p_rel;
    e.busy = (kind != BS_IDLE);
    expect_q.push_back(e);
  endtask

  task automatic check_result();
    pin_result_t e;
    pin_result_t got;
    got.clk = res_ch.clk_level;
    got.dio = res_ch.dio_level;
    got.rel = res_ch.dio_released;
    got.busy = res_ch.busy_res;
    got.acc = res_ch.accepted;
    if (expect_q.size() == 0) begin
      bad_results++;
      if (bad_results <= 10)
        $display("unexpected result: clk=%b dio=%b rel=%b busy=%b acc=%b",
                 got.clk, got.dio, got.rel, got.busy, got.acc);
      return;
    end
    e = expect_q.pop_front();
    if (got.clk !== e.clk || got.dio !== e.dio || got.rel !== e.rel ||
        got.busy !== e.busy || got.acc !== e.acc) begin
      bad_results++;
      if (bad_results <= 10)
        $display("result mismatch (clk dio rel busy acc): exp %b, got %b", e, got);
    end
  endtask

  function automatic bit sender_idles();
    case (drive_mode)
      DM_SEND: return $urandom_range(0, 99) < 48;
      DM_BOTH: return $urandom_range(0, 99) < 8;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (drive_mode)
      DM_RECV: return $urandom_range(0, 99) < 48;
      DM_BOTH: return $urandom_range(0, 99) < 8;
      default: return 1'b0;
    endcase
  endfunction

  // request driver
  always @(negedge clk or posedge rst) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_TICK;
      req_ch.count <= '0;
      req_ch.raw_high <= 8'h00;
      req_ch.raw_low <= 8'h00;
      res_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_fired) begin
        if (pending_reqs.size() != 0 && !sender_idles()) begin
          nxt_req = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= nxt_req.op;
          req_ch.count <= nxt_req.cnt;
          req_ch.raw_high <= nxt_req.hi;
          req_ch.raw_low <= nxt_req.lo;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      res_ch.ready <= !receiver_stalls();
    end
  end

  // result monitor, predictor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      req_fired = 1'b0;
      stall_cycles = 0;
      reset_predictor();
    end else begin
      req_fired = req_ch.valid && req_ch.ready;
      if (res_ch.valid && res_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) cap_model = cfg_ch.capacity;
      if (req_fired) begin
        bar_predict('{op: req_ch.opcode, cnt: req_ch.count,
                      hi: req_ch.raw_high, lo: req_ch.raw_low});
        items_accepted++;
      end
      if (req_fired || (res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic push_req(input logic [1:0] op, input logic [COUNT_WIDTH-1:0] cnt,
                          input logic [7:0] hi, input logic [7:0] lo);
    pending_reqs.push_back('{op: op, cnt: cnt, hi: hi, lo: lo});
    items_pushed++;
    phase_items++;
  endtask

  task automatic push_tick();
    push_req(OP_TICK, COUNT_WIDTH'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_tick();
  endtask

  function automatic logic [COUNT_WIDTH-1:0] pick_count(input logic [COUNT_WIDTH-1:0] cap);
    logic [63:0] v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 36) return COUNT_WIDTH'($urandom);
    v = (64'(cap) * 64'($urandom_range(0, 115))) / 64'd100 + 64'($urandom_range(0, 2));
    if ((v >> COUNT_WIDTH) != 64'd0) return '1;
    return v[COUNT_WIDTH-1:0];
  endfunction

  // one request with the ticks that carry its whole pin sequence, or a bit of noise
  task automatic queue_frame();
    int unsigned r;
    int unsigned n;
    int unsigned full;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) != 0) push_tick();
        else push_req(OPC_UNUSED, COUNT_WIDTH'($urandom), 8'($urandom), 8'($urandom));
      end
      return;
    end
    op = (r < 60) ? OP_LEVEL : OP_RAW;
    push_req(op, pick_count(cap_now), 8'($urandom), 8'($urandom));
    if (op == OP_LEVEL && cap_now == '0) full = 2;
    else full = (op == OP_RAW) ? RAW_TICKS : LEVEL_TICKS;
    n = full + $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      // requests landing mid-sequence must be dropped
      if (i < full && $urandom_range(0, 99) < 2)
        push_req(2'($urandom_range(1, 3)), COUNT_WIDTH'($urandom), 8'($urandom),
                 8'($urandom));
      push_tick();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_pushed || expect_q.size() != 0);
  endtask

  task automatic write_capacity(input logic [COUNT_WIDTH-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.capacity <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cap_now = v;
  endtask

  task automatic run_phase(input drive_mode_t mode, input logic [COUNT_WIDTH-1:0] cap,
                           input int target, input bit hold_midway);
    bit held;
    held = 1'b0;
    wait_drained();
    write_capacity(cap);
    drive_mode = mode;
    phase_items = 0;
    while (phase_items < target) begin
      queue_frame();
      if (hold_midway && !held && phase_items >= target / 2) begin
        wait_drained();
        held = 1'b1;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.capacity <= '0;
    drive_mode = DM_NONE;
    cap_now = '0;
    phase_items = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle tick, unused opcode, level with zero capacity, raw start, drops while busy
    write_capacity('0);
    push_tick();
    push_req(OPC_UNUSED, '1, 8'hFF, 8'hFF);
    push_req(OP_LEVEL, '1, 8'h00, 8'h00);
    push_req(OP_LEVEL, '0, 8'h00, 8'h00);
    push_req(OP_RAW, '0, 8'hFF, 8'h00);
    push_req(OP_RAW, '1, 8'h5A, 8'hA5);
    push_req(OP_LEVEL, COUNT_WIDTH'(1), 8'h00, 8'h00);
    push_req(OPC_UNUSED, '0, 8'h00, 8'h00);
    push_ticks(RAW_TICKS + 2);
    wait_drained();

    // full-scale clamp with the widest count
    write_capacity(COUNT_WIDTH'(100));
    push_req(OP_LEVEL, '1, 8'h00, 8'h00);
    push_ticks(LEVEL_TICKS + 1);

    run_phase(DM_NONE, COUNT_WIDTH'(100), 120, 1'b0);
    run_phase(DM_SEND, '1, 120, 1'b1);
    run_phase(DM_RECV, COUNT_WIDTH'(1), 120, 1'b0);
    run_phase(DM_BOTH, COUNT_WIDTH'($urandom), 120, 1'b0);
    run_phase(DM_NONE, '0, 40, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (bad_results == 0 && expect_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
